[hdl/spz_pkg.sv]
`timescale 1ns / 1ps
package spz_pkg;

	localparam int unsigned SpzN    = 256;
	localparam logic [7:0]  HalfN   = 8'(SpzN / 2);
	localparam logic [3:0]  NibMask = 4'hf;

	// command codes carried in tuser
	typedef enum logic [1:0] {
		REQ_INIT = 2'd0,
		REQ_ABS  = 2'd1,
		REQ_STOP = 2'd2,
		REQ_SQZ  = 2'd3
	} req_e_t;

	// combine modes; the remaining codes give raw keystream
	localparam logic [1:0] MODE_ADD = 2'd0;
	localparam logic [1:0] MODE_SUB = 2'd1;

	// configuration register indexes
	localparam logic REG_MODE = 1'b0;

	typedef enum logic [4:0] {
		ST_CLR,
		ST_IDLE,
		ST_DISP,
		ST_UP_A,
		ST_UP_B,
		ST_UP_C,
		ST_UP_D,
		ST_UP_E,
		ST_CR_A,
		ST_CR_B,
		ST_CR_C,
		ST_CR_D,
		ST_OU_A,
		ST_OU_B,
		ST_OU_C,
		ST_OU_D,
		ST_RES,
		ST_AB_A,
		ST_AB_B,
		ST_AB_C,
		ST_AB_D
	} state_t;

	typedef struct packed {
		req_e_t     req;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic [7:0] addr;
		logic       we;
		logic [7:0] wdata;
	} ram_req_t;

endpackage

[hdl/spz_ram.sv]
`timescale 1ns / 1ps
module spz_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic                     we,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

[hdl/spz_core.sv]
`timescale 1ns / 1ps
module spz_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  spz_pkg::cmd_t     cmd,
	input  logic [1:0]        mode,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [7:0]        res_data,
	output spz_pkg::ram_req_t ram_req,
	input  logic [7:0]        ram_rdata
);
	import spz_pkg::*;

	state_t     state_q, state_d;
	cmd_t       cmd_q;
	logic [7:0] i_q, j_q, k_q, w_q, z_q, cnt_q;
	logic [7:0] si_q;
	logic [8:0] n_q;
	logic [2:0] phase_q;
	logic       shuf_q, nib_hi_q;
	logic [7:0] pos;
	logic [7:0] i_new, k_new, mirror;
	logic       whip_end, crush_end;

	assign pos       = HalfN + {4'd0, (nib_hi_q ? cmd_q.data[7:4] : cmd_q.data[3:0]) & NibMask};
	assign i_new     = i_q + w_q;
	assign k_new     = i_q + k_q + ram_rdata;
	assign mirror    = ~n_q[7:0];
	assign whip_end  = (n_q == 9'd511);
	assign crush_end = (n_q[6:0] == 7'd127);

	assign cmd_ready = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_RES);

	// keystream combine
	always_comb begin
		case (mode)
			MODE_ADD: res_data = cmd_q.data + z_q;
			MODE_SUB: res_data = cmd_q.data - z_q;
			default:  res_data = z_q;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory access
	always_comb begin
		state_d       = state_q;
		ram_req.addr  = '0;
		ram_req.we    = 1'b0;
		ram_req.wdata = '0;
		case (state_q)
			ST_CLR: begin
				ram_req.addr  = n_q[7:0];
				ram_req.we    = 1'b1;
				ram_req.wdata = n_q[7:0];
				if (n_q[7:0] == 8'd255) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid) state_d = ST_DISP;
			end
			ST_DISP: begin
				case (cmd_q.req)
					REQ_INIT: state_d = ST_CLR;
					REQ_ABS:  state_d = (cnt_q == HalfN) ? ST_UP_A : ST_AB_A;
					REQ_STOP: state_d = (cnt_q == HalfN) ? ST_UP_A : ST_IDLE;
					default:  state_d = ST_UP_A;
				endcase
			end
			ST_UP_A: begin
				ram_req.addr = i_new;
				state_d      = ST_UP_B;
			end
			ST_UP_B: begin
				ram_req.addr = j_q + ram_rdata;
				state_d      = ST_UP_C;
			end
			ST_UP_C: begin
				ram_req.addr = k_q + ram_rdata;
				state_d      = ST_UP_D;
			end
			ST_UP_D: begin
				ram_req.addr  = i_q;
				ram_req.we    = 1'b1;
				ram_req.wdata = ram_rdata;
				state_d       = ST_UP_E;
			end
			ST_UP_E: begin
				ram_req.addr  = j_q;
				ram_req.we    = 1'b1;
				ram_req.wdata = si_q;
				if (!shuf_q) begin
					state_d = ST_OU_A;
				end else if (!whip_end) begin
					state_d = ST_UP_A;
				end else if (phase_q == 3'd4) begin
					state_d = ST_DISP;
				end else begin
					state_d = ST_CR_A;
				end
			end
			ST_CR_A: begin
				ram_req.addr = n_q[7:0];
				state_d      = ST_CR_B;
			end
			ST_CR_B: begin
				ram_req.addr = mirror;
				state_d      = ST_CR_C;
			end
			ST_CR_C: begin
				if (si_q > ram_rdata) begin
					ram_req.addr  = n_q[7:0];
					ram_req.we    = 1'b1;
					ram_req.wdata = ram_rdata;
					state_d       = ST_CR_D;
				end else begin
					state_d = crush_end ? ST_UP_A : ST_CR_A;
				end
			end
			ST_CR_D: begin
				ram_req.addr  = mirror;
				ram_req.we    = 1'b1;
				ram_req.wdata = si_q;
				state_d       = crush_end ? ST_UP_A : ST_CR_A;
			end
			ST_OU_A: begin
				ram_req.addr = z_q + k_q;
				state_d      = ST_OU_B;
			end
			ST_OU_B: begin
				ram_req.addr = i_q + ram_rdata;
				state_d      = ST_OU_C;
			end
			ST_OU_C: begin
				ram_req.addr = j_q + ram_rdata;
				state_d      = ST_OU_D;
			end
			ST_OU_D: begin
				state_d = ST_RES;
			end
			ST_RES: begin
				if (res_ready) state_d = ST_IDLE;
			end
			ST_AB_A: begin
				ram_req.addr = cnt_q;
				state_d      = ST_AB_B;
			end
			ST_AB_B: begin
				ram_req.addr = pos;
				state_d      = ST_AB_C;
			end
			ST_AB_C: begin
				ram_req.addr  = cnt_q;
				ram_req.we    = 1'b1;
				ram_req.wdata = ram_rdata;
				state_d       = ST_AB_D;
			end
			ST_AB_D: begin
				ram_req.addr  = pos;
				ram_req.we    = 1'b1;
				ram_req.wdata = si_q;
				state_d       = nib_hi_q ? ST_IDLE : ST_DISP;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sponge registers and loop counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
			w_q      <= 8'd1;
			z_q      <= '0;
			cnt_q    <= '0;
			si_q     <= '0;
			n_q      <= '0;
			phase_q  <= '0;
			shuf_q   <= 1'b0;
			nib_hi_q <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: n_q <= n_q + 9'd1;
				ST_IDLE: begin
					nib_hi_q <= 1'b0;
					n_q      <= '0;
				end
				ST_DISP: begin
					case (cmd_q.req)
						REQ_INIT: begin
							i_q   <= '0;
							j_q   <= '0;
							k_q   <= '0;
							w_q   <= 8'd1;
							z_q   <= '0;
							cnt_q <= '0;
						end
						REQ_ABS, REQ_STOP: begin
							if (cnt_q == HalfN) begin
								shuf_q  <= 1'b1;
								phase_q <= '0;
							end else if (cmd_q.req == REQ_STOP) begin
								cnt_q <= cnt_q + 8'd1;
							end
						end
						default: begin
							if (cnt_q != 8'd0) begin
								shuf_q  <= 1'b1;
								phase_q <= '0;
							end
						end
					endcase
					n_q <= '0;
				end
				ST_UP_A: i_q <= i_new;
				ST_UP_B: si_q <= ram_rdata;
				ST_UP_C: j_q <= k_q + ram_rdata;
				ST_UP_D: k_q <= k_new;
				ST_UP_E: begin
					if (shuf_q) begin
						n_q <= whip_end ? 9'd0 : n_q + 9'd1;
						if (whip_end) begin
							w_q <= w_q + 8'd2;
							if (phase_q == 3'd4) begin
								shuf_q <= 1'b0;
								cnt_q  <= '0;
							end else begin
								phase_q <= phase_q + 3'd1;
							end
						end
					end
				end
				ST_CR_B: si_q <= ram_rdata;
				ST_CR_C, ST_CR_D: begin
					if (state_d != ST_CR_D) begin
						n_q <= crush_end ? 9'd0 : n_q + 9'd1;
						if (crush_end) phase_q <= phase_q + 3'd1;
					end
				end
				ST_OU_D: z_q <= ram_rdata;
				ST_AB_B: si_q <= ram_rdata;
				ST_AB_D: begin
					cnt_q    <= cnt_q + 8'd1;
					nib_hi_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// latch the command on transfer
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
	end

`ifndef ASSERT_OFF
	a_leave_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> state_q == ST_DISP)
		else $error("accepted command not dispatched");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= HalfN)
		else $error("absorb count beyond half");
	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		shuf_q |-> phase_q <= 3'd4)
		else $error("shuffle phase out of range");
	a_no_write_while_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE || state_q == ST_RES |-> !ram_req.we)
		else $error("permutation written while idle");
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(z_q))
		else $error("pending result lost");
`endif

endmodule

[hdl/spritz_sponge_cipher_top.sv]
`timescale 1ns / 1ps
// Spritz sponge engine.
// Commands arrive on the s_ stream: tuser carries the command code (init,
// absorb byte, absorb stop, squeeze) and tdata the byte. Only a squeeze gives
// a result, one byte on the m_ stream. An APB port holds combine_mode at
// address 0: add keystream, subtract keystream, or raw keystream.
// The permutation lives in one 256x8 single-port RAM; every step reads,
// modifies and writes it one access per cycle. A drip is an update plus an
// output; a full shuffle, three whips of 512 updates and two crushes, is
// taken when due. Init and reset rewrite the identity permutation, and
// s_tready is low meanwhile; configuration writes are taken at any time.
// A result waits in an output register; the next command is taken while it
// waits, and only a further squeeze stalls until the receiver takes it.
module spritz_sponge_cipher_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_in
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] data_out
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import spz_pkg::*;

	logic       [1:0] mode_q;
	cmd_t             cmd;
	ram_req_t         ram_req;
	logic       [7:0] ram_rdata;
	logic             res_valid, res_ready;
	logic       [7:0] res_data;
	logic             m_tvalid_q;
	logic       [7:0] m_tdata_q;

	// configuration register
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_MODE) ? {30'd0, mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_ADD;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_MODE) begin
			mode_q <= pwdata[1:0];
		end
	end

	assign cmd.req  = req_e_t'(s_tuser);
	assign cmd.data = s_tdata;

	spz_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.cmd_ready (s_tready),
		.cmd       (cmd),
		.mode      (mode_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata)
	);

	spz_ram #(
		.WIDTH (8),
		.DEPTH (256)
	) u_perm (
		.clk   (clk),
		.addr  (ram_req.addr),
		.we    (ram_req.we),
		.wdata (ram_req.wdata),
		.rdata (ram_rdata)
	);

	// output register
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= res_data;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
